// File: rtl/core/qsd_pkg.sv
// Package for the query string percent decoder.
// Holds the result codes, the pair state, the per-item step record and the hex digit decode.
// No dependencies.
package qsd_pkg;

    localparam int unsigned MaxResults = 2;
    localparam int unsigned QueueDepth = 2;

    localparam logic [7:0] ChEquals  = 8'h3D;
    localparam logic [7:0] ChAmp     = 8'h26;
    localparam logic [7:0] ChPercent = 8'h25;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_VALUE   = 2'd1,
        KIND_VALID   = 2'd2,
        KIND_DISCARD = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_PERCENT = 2'd1,
        ESC_HIGH    = 2'd2
    } t_esc;

    typedef struct packed {
        logic       in_value;
        t_esc       escape_stage;
        logic [3:0] high_nibble;
        logic       pair_bad;
        logic       name_started;
    } t_state;

    localparam t_state StateReset = '{
        in_value:     1'b0,
        escape_stage: ESC_NONE,
        high_nibble:  4'd0,
        pair_bad:     1'b0,
        name_started: 1'b0
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
    } t_result;

    // One queue entry holds every result of one item; res[0] goes out first.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_entry;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: rtl/core/qsd_if.sv
// Handshake channels of the query string percent decoder.
// Depends on qsd_pkg for the result kind type.
interface qsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_req;

    modport source (output valid, output in_byte, output final_req, input ready);
    modport sink (input valid, input in_byte, input final_req, output ready);
endinterface

interface qsd_out_if;
    logic          valid;
    logic          ready;
    qsd_pkg::t_kind kind;
    logic [7:0]    out_byte;

    modport source (output valid, output kind, output out_byte, input ready);
    modport sink (input valid, input kind, input out_byte, output ready);
endinterface

// File: rtl/core/qsd_step.sv
// Per-item decode step: from the pair state and one input byte, forms up to two results
// and the next pair state. Purely combinational. Depends on qsd_pkg.
module qsd_step (
    input  qsd_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output qsd_pkg::t_entry o_entry,
    output qsd_pkg::t_state o_state
);

    always_comb begin
        qsd_pkg::t_state s;
        qsd_pkg::t_entry e;
        qsd_pkg::t_hex   h;
        qsd_pkg::t_result r;
        logic            bad;
        s = i_state;
        e = '0;
        h = qsd_pkg::hex_val(i_byte);
        r = '0;
        bad = 1'b0;
        if (!s.in_value) begin
            if (i_byte == qsd_pkg::ChEquals) begin
                s.in_value = 1'b1;
                s.escape_stage = qsd_pkg::ESC_NONE;
                s.pair_bad = 1'b0;
                if (i_last) begin
                    e.cnt = 2'd1;
                    e.res0 = '{kind: qsd_pkg::KIND_VALID, out_byte: 8'd0};
                    s = qsd_pkg::StateReset;
                end
            end else begin
                e.cnt = 2'd1;
                e.res0 = '{kind: qsd_pkg::KIND_NAME, out_byte: i_byte};
                s.name_started = 1'b1;
                if (i_last) begin
                    e.cnt = 2'd2;
                    e.res1 = '{kind: qsd_pkg::KIND_DISCARD, out_byte: 8'd0};
                    s = qsd_pkg::StateReset;
                end
            end
        end else if (i_byte == qsd_pkg::ChAmp) begin
            bad = s.pair_bad || (s.escape_stage != qsd_pkg::ESC_NONE);
            e.cnt = 2'd1;
            e.res0.kind = bad ? qsd_pkg::KIND_DISCARD : qsd_pkg::KIND_VALID;
            e.res0.out_byte = 8'd0;
            s = qsd_pkg::StateReset;
        end else begin
            if (!s.pair_bad) begin
                if (s.escape_stage == qsd_pkg::ESC_NONE) begin
                    if (i_byte == qsd_pkg::ChPercent) begin
                        s.escape_stage = qsd_pkg::ESC_PERCENT;
                    end else begin
                        e.cnt = 2'd1;
                        e.res0 = '{kind: qsd_pkg::KIND_VALUE, out_byte: i_byte};
                    end
                end else if (!h.ok) begin
                    s.pair_bad = 1'b1;
                    s.escape_stage = qsd_pkg::ESC_NONE;
                    s.high_nibble = 4'd0;
                end else if (s.escape_stage == qsd_pkg::ESC_PERCENT) begin
                    s.high_nibble = h.val;
                    s.escape_stage = qsd_pkg::ESC_HIGH;
                end else begin
                    e.cnt = 2'd1;
                    e.res0 = '{kind: qsd_pkg::KIND_VALUE, out_byte: {s.high_nibble, h.val}};
                    s.escape_stage = qsd_pkg::ESC_NONE;
                    s.high_nibble = 4'd0;
                end
            end
            if (i_last) begin
                bad = s.pair_bad || (s.escape_stage != qsd_pkg::ESC_NONE);
                r.kind = bad ? qsd_pkg::KIND_DISCARD : qsd_pkg::KIND_VALID;
                r.out_byte = 8'd0;
                if (e.cnt == 2'd0) begin
                    e.res0 = r;
                end else begin
                    e.res1 = r;
                end
                e.cnt = e.cnt + 2'd1;
                s = qsd_pkg::StateReset;
            end
        end
        o_entry = e;
        o_state = s;
    end

endmodule

// File: rtl/core/query_string_percent_decoder.sv
// Query string percent decoder: takes one byte of a query string per item, with a flag on
// the last byte, and gives name bytes, decoded value bytes and pair end markers, one per
// output item. A byte is taken into an input register, decoded combinationally against the
// pair state, and its results (one or two) are written as one entry into a two-entry
// result queue; a byte with no result writes no entry. Input items are accepted every cycle
// as long as output items are taken; an input byte that yields two results holds the input
// side back, because the output port delivers one result per cycle. Depends on qsd_pkg,
// qsd_if and qsd_step.
module query_string_percent_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qsd_in_if.sink    i_in_ch,
    qsd_out_if.source o_out_ch
);

    logic            r_item_valid;
    logic [7:0]      r_item_byte;
    logic            r_item_last;
    qsd_pkg::t_state r_state;
    qsd_pkg::t_state n_state;
    qsd_pkg::t_entry step_entry;

    qsd_pkg::t_entry r_q [qsd_pkg::QueueDepth];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;
    logic            r_sub;

    qsd_pkg::t_entry head;
    qsd_pkg::t_result head_res;
    logic            pop_entry;
    logic            take;
    logic            push;

    qsd_step u_step (
        .i_state (r_state),
        .i_byte  (r_item_byte),
        .i_last  (r_item_last),
        .o_entry (step_entry),
        .o_state (n_state)
    );

    assign head      = r_q[r_rd];
    assign head_res  = r_sub ? head.res1 : head.res0;
    assign pop_entry = o_out_ch.valid && o_out_ch.ready && (r_sub == (head.cnt == 2'd2));
    assign take      = r_item_valid && ((r_count != 2'd2) || pop_entry);
    assign push      = take && (step_entry.cnt != 2'd0);

    assign i_in_ch.ready     = !r_item_valid || take;
    assign o_out_ch.valid    = (r_count != 2'd0);
    assign o_out_ch.kind     = head_res.kind;
    assign o_out_ch.out_byte = head_res.out_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_state      <= qsd_pkg::StateReset;
            r_wr         <= 1'b0;
            r_rd         <= 1'b0;
            r_count      <= 2'd0;
            r_sub        <= 1'b0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                r_item_valid <= 1'b1;
            end else if (take) begin
                r_item_valid <= 1'b0;
            end
            if (take) begin
                r_state <= n_state;
            end
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop_entry) begin
                r_rd  <= !r_rd;
                r_sub <= 1'b0;
            end else if (o_out_ch.valid && o_out_ch.ready) begin
                r_sub <= 1'b1;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop_entry};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_item_byte <= i_in_ch.in_byte;
            r_item_last <= i_in_ch.final_req;
        end
        if (push) begin
            r_q[r_wr] <= step_entry;
        end
    end

endmodule
